@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FTCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FTCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ftcp_pkg.sv @@
// Shared types, constants and functions of the floppy track CRC patcher.
// No dependencies; used by every RTL file of the block.
package ftcp_pkg;

  localparam int MAX_TRACK_BYTES = 8192;
  localparam int AW = $clog2(MAX_TRACK_BYTES);
  localparam int LW = AW + 1;
  // positions reach past the track by up to one largest data field
  localparam int PW = 25;
  localparam int JW = 7;
  localparam int OW = 4;

  localparam logic [7:0] MARK_ID   = 8'hFE;
  localparam logic [7:0] FILL      = 8'hF7;
  localparam logic [7:0] DAM       = 8'hFB;
  localparam logic [7:0] DDAM      = 8'hF8;
  localparam logic [7:0] SYNC      = 8'hA1;
  localparam logic [7:0] CLK_MARK  = 8'hC7;
  localparam logic [7:0] CLK_SYNC  = 8'h0A;
  localparam logic [7:0] CLK_DATA  = 8'hFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam int SIZE_BASE     = 128;
  localparam int MAX_SIZE_CODE = 16;

  // search window bounds, counted from the ID mark
  localparam logic [JW-1:0] FM_SRCH_FIRST = 7'd12;
  localparam logic [JW-1:0] FM_SRCH_END   = 7'd32;
  localparam logic [JW-1:0] MFM_SRCH_END  = 7'd64;

  // offsets used by the sequencer
  localparam logic [OW-1:0] OFF_ZERO    = 4'd0;
  localparam logic [OW-1:0] OFF_CODE    = 4'd4;
  localparam logic [OW-1:0] OFF_FILL0   = 4'd5;
  localparam logic [OW-1:0] OFF_FILL1   = 4'd6;
  localparam logic [OW-1:0] OFF_SYNC    = 4'd3;
  localparam logic [OW-1:0] OFF_MARKLEN = 4'd4;
  localparam logic [OW-1:0] FM_ID_LEN   = 4'd5;
  localparam logic [OW-1:0] MFM_ID_LEN  = 4'd8;
  localparam logic [OW-1:0] FM_DFILL0   = 4'd1;
  localparam logic [OW-1:0] FM_DFILL1   = 4'd2;
  localparam logic [OW-1:0] MFM_DFILL0  = 4'd4;
  localparam logic [OW-1:0] MFM_DFILL1  = 4'd5;
  localparam logic [OW-1:0] FM_RESUME   = 4'd3;
  localparam logic [OW-1:0] MFM_RESUME  = 4'd6;

  // configuration register index (paddr[2])
  localparam logic REG_ENCODING_MODE = 1'b0;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] track_byte;
    logic [7:0] clock_byte;
    logic       final_position;
    logic [7:0] sector_count;
  } out_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SCAN, ST_FM_FE, ST_MSY, ST_MCLK, ST_MID, ST_I5, ST_I6, ST_CODE,
    ST_SPAN, ST_HI, ST_LO, ST_SR, ST_FM_M, ST_DPROBE, ST_D1, ST_D2, ST_NEXT,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    PTR_HOLD, PTR_BASE_OFF, PTR_BASE_J, PTR_START, PTR_SS_OFF, PTR_INC
  } ptr_op_t;

  typedef enum logic [2:0] {
    BASE_HOLD, BASE_ZERO, BASE_INC, BASE_ADD_OFF, BASE_J_OFF, BASE_SS_OFF
  } base_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_OFF, CNT_SIZE_OFF, CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    J_HOLD, J_SET, J_INC
  } j_op_t;

  typedef struct packed {
    logic          pass;
    ptr_op_t       ptr_op;
    base_op_t      base_op;
    cnt_op_t       cnt_op;
    j_op_t         j_op;
    logic [OW-1:0] off;
    logic [JW-1:0] j_val;
    logic          start_load;
    logic          size_load;
    logic          crc_init;
    logic          crc_feed;
    logic          trk_we;
    logic          trk_lo;
    logic          clk_we;
    logic [7:0]    clk_val;
    logic          sect_clr;
    logic          sect_inc;
  } cmd_t;

  typedef struct packed {
    logic          nm;
    logic [7:0]    data;
    logic          base_done;
    logic          cnt_one;
    logic [JW-1:0] j;
    logic          mode;
  } sts_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int n = 0; n < 8; n++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [PW-1:0] field_size(input logic [7:0] code);
    logic [4:0] c;
    c = (code > 8'(MAX_SIZE_CODE)) ? 5'(MAX_SIZE_CODE) : code[4:0];
    return PW'(SIZE_BASE) << c;
  endfunction

endpackage

@@ hw/rtl/floppy_track_crc_patcher_top.sv @@
// Usage of the floppy track CRC patcher.
// Command channel: a request is taken at a clock edge with start high and busy
// low. operation 0 loads data_byte as the next track byte (clock preset FF);
// last_byte ends the track and starts the patch pass. operation 1 reads the
// next position of the patched track.
// Result channel: out_valid marks out_data for one cycle, in the cycle after the
// read request; the receiver cannot stall it. Loads give no result, and a read
// of an empty track gives none.
// Throughput: loads and reads take one request per cycle while busy is low. The
// patch pass holds busy high while one sequencer walks the stored track through
// the single read port.
// encoding_mode sits at byte address 0 of the APB port (1 = FM, 0 = MFM).
// Reset clears pointers, length, sector count and mode; the memories are not
// cleared, every position below the track length is written before it is read.
// Depends on ftcp_pkg, ftcp_ctrl and ftcp_dp.
module floppy_track_crc_patcher_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ftcp_pkg::in_req_t   in_req,
  output logic                out_valid,
  output ftcp_pkg::out_rsp_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  ftcp_pkg::cmd_t cmd;
  ftcp_pkg::sts_t sts;
  logic           go;
  logic           in_acc;

  assign in_acc = start && !busy;

  ftcp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ftcp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .go        (go),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

endmodule

@@ hw/rtl/ftcp_ctrl.sv @@
// Patch-pass sequencer of the floppy track CRC patcher.
// Depends on ftcp_pkg; drives ftcp_dp through cmd_t and watches sts_t.
module ftcp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  ftcp_pkg::sts_t  sts,
  output ftcp_pkg::cmd_t  cmd,
  output logic            busy
);

  ftcp_pkg::state_t state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic       srch_r, srch_nxt;
  logic       data_r, data_nxt;

  logic       hit_fe, hit_f7, hit_dm, hit_sync;
  logic [7:0] sync_exp;
  logic [ftcp_pkg::JW-1:0] j_lim;

  always_comb begin
    sync_exp = (k_r != 2'd3) ? ftcp_pkg::SYNC :
               (srch_r ? ftcp_pkg::DAM : ftcp_pkg::MARK_ID);
    hit_fe   = !sts.nm && (sts.data == ftcp_pkg::MARK_ID);
    hit_f7   = !sts.nm && (sts.data == ftcp_pkg::FILL);
    hit_dm   = !sts.nm && ((sts.data == ftcp_pkg::DAM) || (sts.data == ftcp_pkg::DDAM));
    hit_sync = !sts.nm && (sts.data == sync_exp);
    j_lim    = sts.mode ? ftcp_pkg::FM_SRCH_END : ftcp_pkg::MFM_SRCH_END;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ftcp_pkg::ST_IDLE;
      k_r     <= 2'd0;
      srch_r  <= 1'b0;
      data_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      srch_r  <= srch_nxt;
      data_r  <= data_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    srch_nxt  = srch_r;
    data_nxt  = data_r;
    case (state_r)
      ftcp_pkg::ST_IDLE:   if (go) state_nxt = ftcp_pkg::ST_SCAN;
      ftcp_pkg::ST_SCAN: begin
        if (sts.base_done) begin
          state_nxt = ftcp_pkg::ST_FIN;
        end else begin
          k_nxt     = 2'd0;
          srch_nxt  = 1'b0;
          state_nxt = sts.mode ? ftcp_pkg::ST_FM_FE : ftcp_pkg::ST_MSY;
        end
      end
      ftcp_pkg::ST_FM_FE:  state_nxt = hit_fe ? ftcp_pkg::ST_I5 : ftcp_pkg::ST_NEXT;
      ftcp_pkg::ST_MSY: begin
        if (hit_sync) begin
          k_nxt = k_r + 2'd1;
          if (k_r == 2'd3) state_nxt = ftcp_pkg::ST_MCLK;
        end else begin
          state_nxt = srch_r ? ftcp_pkg::ST_SR : ftcp_pkg::ST_NEXT;
        end
      end
      ftcp_pkg::ST_MCLK: begin
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd3) state_nxt = srch_r ? ftcp_pkg::ST_DPROBE : ftcp_pkg::ST_MID;
      end
      ftcp_pkg::ST_MID:    state_nxt = ftcp_pkg::ST_I5;
      ftcp_pkg::ST_I5:     state_nxt = hit_f7 ? ftcp_pkg::ST_I6 : ftcp_pkg::ST_NEXT;
      ftcp_pkg::ST_I6:     state_nxt = hit_f7 ? ftcp_pkg::ST_CODE : ftcp_pkg::ST_NEXT;
      ftcp_pkg::ST_CODE: begin
        data_nxt  = 1'b0;
        state_nxt = ftcp_pkg::ST_SPAN;
      end
      ftcp_pkg::ST_SPAN:   if (sts.cnt_one) state_nxt = ftcp_pkg::ST_HI;
      ftcp_pkg::ST_HI:     state_nxt = ftcp_pkg::ST_LO;
      ftcp_pkg::ST_LO: begin
        if (data_r) begin
          state_nxt = ftcp_pkg::ST_NEXT;
        end else begin
          srch_nxt  = 1'b1;
          state_nxt = ftcp_pkg::ST_SR;
        end
      end
      ftcp_pkg::ST_SR: begin
        if (sts.j == j_lim) begin
          state_nxt = ftcp_pkg::ST_NEXT;
        end else begin
          k_nxt     = 2'd0;
          state_nxt = sts.mode ? ftcp_pkg::ST_FM_M : ftcp_pkg::ST_MSY;
        end
      end
      ftcp_pkg::ST_FM_M:   state_nxt = hit_dm ? ftcp_pkg::ST_DPROBE : ftcp_pkg::ST_SR;
      ftcp_pkg::ST_DPROBE: state_nxt = ftcp_pkg::ST_D1;
      ftcp_pkg::ST_D1:     state_nxt = hit_f7 ? ftcp_pkg::ST_D2 : ftcp_pkg::ST_SR;
      ftcp_pkg::ST_D2: begin
        if (hit_f7) begin
          data_nxt  = 1'b1;
          state_nxt = ftcp_pkg::ST_SPAN;
        end else begin
          state_nxt = ftcp_pkg::ST_SR;
        end
      end
      ftcp_pkg::ST_NEXT:   state_nxt = ftcp_pkg::ST_SCAN;
      ftcp_pkg::ST_FIN:    state_nxt = ftcp_pkg::ST_IDLE;
      default:             state_nxt = ftcp_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.ptr_op     = ftcp_pkg::PTR_HOLD;
    cmd.base_op    = ftcp_pkg::BASE_HOLD;
    cmd.cnt_op     = ftcp_pkg::CNT_HOLD;
    cmd.j_op       = ftcp_pkg::J_HOLD;
    cmd.clk_val    = ftcp_pkg::CLK_DATA;
    cmd.pass       = (state_r != ftcp_pkg::ST_IDLE);
    busy           = cmd.pass;
    case (state_r)
      ftcp_pkg::ST_IDLE: begin
        if (go) begin
          cmd.base_op  = ftcp_pkg::BASE_ZERO;
          cmd.sect_clr = 1'b1;
        end
      end
      ftcp_pkg::ST_SCAN: begin
        cmd.ptr_op = ftcp_pkg::PTR_BASE_OFF;
        cmd.off    = ftcp_pkg::OFF_ZERO;
        cmd.j_op   = ftcp_pkg::J_SET;
        cmd.j_val  = '0;
      end
      ftcp_pkg::ST_FM_FE: begin
        if (hit_fe) begin
          cmd.clk_we     = 1'b1;
          cmd.clk_val    = ftcp_pkg::CLK_MARK;
          cmd.start_load = 1'b1;
          cmd.ptr_op     = ftcp_pkg::PTR_BASE_OFF;
          cmd.off        = ftcp_pkg::OFF_FILL0;
        end
      end
      ftcp_pkg::ST_MSY: begin
        if (hit_sync) begin
          cmd.ptr_op = (k_r == 2'd3) ? ftcp_pkg::PTR_BASE_J : ftcp_pkg::PTR_INC;
        end else if (srch_r) begin
          cmd.j_op = ftcp_pkg::J_INC;
        end
      end
      ftcp_pkg::ST_MCLK: begin
        cmd.clk_we  = 1'b1;
        cmd.clk_val = (k_r == 2'd3) ? ftcp_pkg::CLK_DATA : ftcp_pkg::CLK_SYNC;
        cmd.ptr_op  = ftcp_pkg::PTR_INC;
        if (k_r == 2'd3) begin
          cmd.start_load = 1'b1;
          cmd.base_op    = srch_r ? ftcp_pkg::BASE_J_OFF : ftcp_pkg::BASE_ADD_OFF;
          cmd.off        = srch_r ? ftcp_pkg::OFF_MARKLEN : ftcp_pkg::OFF_SYNC;
        end
      end
      ftcp_pkg::ST_MID: begin
        cmd.ptr_op = ftcp_pkg::PTR_BASE_OFF;
        cmd.off    = ftcp_pkg::OFF_FILL0;
      end
      ftcp_pkg::ST_I5: begin
        if (hit_f7) begin
          cmd.ptr_op = ftcp_pkg::PTR_BASE_OFF;
          cmd.off    = ftcp_pkg::OFF_FILL1;
        end
      end
      ftcp_pkg::ST_I6: begin
        if (hit_f7) begin
          cmd.ptr_op = ftcp_pkg::PTR_BASE_OFF;
          cmd.off    = ftcp_pkg::OFF_CODE;
        end
      end
      ftcp_pkg::ST_CODE: begin
        cmd.size_load = 1'b1;
        cmd.crc_init  = 1'b1;
        cmd.cnt_op    = ftcp_pkg::CNT_OFF;
        cmd.off       = sts.mode ? ftcp_pkg::FM_ID_LEN : ftcp_pkg::MFM_ID_LEN;
        cmd.ptr_op    = ftcp_pkg::PTR_START;
      end
      ftcp_pkg::ST_SPAN: begin
        cmd.crc_feed = 1'b1;
        cmd.ptr_op   = ftcp_pkg::PTR_INC;
        cmd.cnt_op   = ftcp_pkg::CNT_DEC;
      end
      ftcp_pkg::ST_HI: begin
        cmd.trk_we = 1'b1;
        cmd.clk_we = data_r && !sts.mode;
        cmd.ptr_op = ftcp_pkg::PTR_INC;
      end
      ftcp_pkg::ST_LO: begin
        cmd.trk_we = 1'b1;
        cmd.trk_lo = 1'b1;
        cmd.clk_we = data_r && !sts.mode;
        if (data_r) begin
          cmd.sect_inc = 1'b1;
          cmd.base_op  = ftcp_pkg::BASE_SS_OFF;
          cmd.off      = sts.mode ? ftcp_pkg::FM_RESUME : ftcp_pkg::MFM_RESUME;
        end else begin
          cmd.j_op  = ftcp_pkg::J_SET;
          cmd.j_val = sts.mode ? ftcp_pkg::FM_SRCH_FIRST : '0;
        end
      end
      ftcp_pkg::ST_SR: begin
        if (sts.j != j_lim) cmd.ptr_op = ftcp_pkg::PTR_BASE_J;
      end
      ftcp_pkg::ST_FM_M: begin
        if (hit_dm) begin
          cmd.clk_we     = 1'b1;
          cmd.clk_val    = ftcp_pkg::CLK_MARK;
          cmd.start_load = 1'b1;
        end else begin
          cmd.j_op = ftcp_pkg::J_INC;
        end
      end
      ftcp_pkg::ST_DPROBE: begin
        cmd.ptr_op = ftcp_pkg::PTR_SS_OFF;
        cmd.off    = sts.mode ? ftcp_pkg::FM_DFILL0 : ftcp_pkg::MFM_DFILL0;
      end
      ftcp_pkg::ST_D1: begin
        if (hit_f7) begin
          cmd.ptr_op = ftcp_pkg::PTR_SS_OFF;
          cmd.off    = sts.mode ? ftcp_pkg::FM_DFILL1 : ftcp_pkg::MFM_DFILL1;
        end else begin
          cmd.j_op = ftcp_pkg::J_INC;
        end
      end
      ftcp_pkg::ST_D2: begin
        if (hit_f7) begin
          cmd.crc_init = 1'b1;
          cmd.cnt_op   = ftcp_pkg::CNT_SIZE_OFF;
          cmd.off      = sts.mode ? ftcp_pkg::FM_DFILL0 : ftcp_pkg::MFM_DFILL0;
          cmd.ptr_op   = ftcp_pkg::PTR_START;
        end else begin
          cmd.j_op = ftcp_pkg::J_INC;
        end
      end
      ftcp_pkg::ST_NEXT:   cmd.base_op = ftcp_pkg::BASE_INC;
      ftcp_pkg::ST_FIN:    cmd.pass = 1'b1;
      default:             cmd.pass = 1'b1;
    endcase
  end

endmodule

@@ hw/rtl/ftcp_dp.sv @@
// Datapath of the floppy track CRC patcher: track and clock memories,
// pointers, CRC register, sector counter and configuration register. Uses ftcp_pkg.
module ftcp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_acc,
  input  ftcp_pkg::in_req_t   in_req,
  input  ftcp_pkg::cmd_t      cmd,
  output ftcp_pkg::sts_t      sts,
  output logic                go,
  output logic                out_valid,
  output ftcp_pkg::out_rsp_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int AW = ftcp_pkg::AW;
  localparam int LW = ftcp_pkg::LW;
  localparam int PW = ftcp_pkg::PW;
  localparam int JW = ftcp_pkg::JW;

  logic [7:0] trk_mem [ftcp_pkg::MAX_TRACK_BYTES];
  logic [7:0] clk_mem [ftcp_pkg::MAX_TRACK_BYTES];
  logic [7:0] trk_q_r, clk_q_r;

  logic [LW-1:0] lp_r, len_r, rp_r;
  logic [PW-1:0] base_r, base_nxt, start_r, ptr_r, ptr_nxt, size_r, cnt_r, cnt_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic [15:0]   crc_r;
  logic [7:0]    sect_r, sect_out_r;
  logic          mode_r, out_valid_r, final_r;

  logic          ld_we, rd_acc, trk_we, clk_we, cfg_we;
  logic [AW-1:0] trk_wa, clk_wa, trk_ra, clk_ra;
  logic [7:0]    trk_wd, clk_wd;
  logic [LW:0]   rp_inc;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == ftcp_pkg::REG_ENCODING_MODE);
  assign prdata = (paddr[2] == ftcp_pkg::REG_ENCODING_MODE) ? 32'(mode_r) : '0;

  assign ld_we  = in_acc && !in_req.operation && (lp_r < LW'(ftcp_pkg::MAX_TRACK_BYTES));
  assign go     = in_acc && !in_req.operation && in_req.last_byte;
  assign rd_acc = in_acc && in_req.operation && (len_r != '0);
  assign rp_inc = {1'b0, rp_r} + 1'b1;

  // pointer and counter arithmetic of the patch pass
  always_comb begin
    case (cmd.ptr_op)
      ftcp_pkg::PTR_BASE_OFF: ptr_nxt = base_r + PW'(cmd.off);
      ftcp_pkg::PTR_BASE_J:   ptr_nxt = base_r + PW'(j_r);
      ftcp_pkg::PTR_START:    ptr_nxt = start_r;
      ftcp_pkg::PTR_SS_OFF:   ptr_nxt = start_r + size_r + PW'(cmd.off);
      ftcp_pkg::PTR_INC:      ptr_nxt = ptr_r + 1'b1;
      default:                ptr_nxt = ptr_r;
    endcase
    case (cmd.base_op)
      ftcp_pkg::BASE_ZERO:    base_nxt = '0;
      ftcp_pkg::BASE_INC:     base_nxt = base_r + 1'b1;
      ftcp_pkg::BASE_ADD_OFF: base_nxt = base_r + PW'(cmd.off);
      ftcp_pkg::BASE_J_OFF:   base_nxt = base_r + PW'(j_r) + PW'(cmd.off);
      ftcp_pkg::BASE_SS_OFF:  base_nxt = start_r + size_r + PW'(cmd.off);
      default:                base_nxt = base_r;
    endcase
    case (cmd.cnt_op)
      ftcp_pkg::CNT_OFF:      cnt_nxt = PW'(cmd.off);
      ftcp_pkg::CNT_SIZE_OFF: cnt_nxt = size_r + PW'(cmd.off);
      ftcp_pkg::CNT_DEC:      cnt_nxt = cnt_r - 1'b1;
      default:                cnt_nxt = cnt_r;
    endcase
    case (cmd.j_op)
      ftcp_pkg::J_SET:        j_nxt = cmd.j_val;
      ftcp_pkg::J_INC:        j_nxt = j_r + 1'b1;
      default:                j_nxt = j_r;
    endcase
  end

  // memory port selection: load and readout when idle, sequencer otherwise
  always_comb begin
    trk_we = ld_we || cmd.trk_we;
    clk_we = ld_we || cmd.clk_we;
    trk_wa = ld_we ? lp_r[AW-1:0] : ptr_r[AW-1:0];
    clk_wa = trk_wa;
    trk_wd = ld_we ? in_req.data_byte : (cmd.trk_lo ? crc_r[7:0] : crc_r[15:8]);
    clk_wd = ld_we ? ftcp_pkg::CLK_DATA : cmd.clk_val;
    trk_ra = cmd.pass ? ptr_nxt[AW-1:0] : rp_r[AW-1:0];
    clk_ra = rp_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (trk_we) trk_mem[trk_wa] <= trk_wd;
    trk_q_r <= trk_mem[trk_ra];
  end

  always_ff @(posedge clk) begin
    if (clk_we) clk_mem[clk_wa] <= clk_wd;
    clk_q_r <= clk_mem[clk_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r        <= '0;
      len_r       <= '0;
      rp_r        <= '0;
      sect_r      <= '0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      j_r         <= '0;
      crc_r       <= ftcp_pkg::CRC_INIT;
    end else begin
      out_valid_r <= rd_acc;
      if (cfg_we) mode_r <= pwdata[0];
      if (go) begin
        len_r <= ld_we ? (lp_r + 1'b1) : lp_r;
        lp_r  <= '0;
        rp_r  <= '0;
      end else begin
        if (ld_we) lp_r <= lp_r + 1'b1;
        if (rd_acc) rp_r <= (rp_inc == {1'b0, len_r}) ? '0 : rp_inc[LW-1:0];
      end
      if (cmd.sect_clr) begin
        sect_r <= '0;
      end else if (cmd.sect_inc && (sect_r != 8'hFF)) begin
        sect_r <= sect_r + 1'b1;
      end
      base_r <= base_nxt;
      ptr_r  <= ptr_nxt;
      cnt_r  <= cnt_nxt;
      j_r    <= j_nxt;
      if (cmd.crc_init) begin
        crc_r <= ftcp_pkg::CRC_INIT;
      end else if (cmd.crc_feed) begin
        crc_r <= ftcp_pkg::crc16_byte(crc_r, sts.data);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start_load) start_r <= base_r + PW'(j_r);
    if (cmd.size_load)  size_r  <= ftcp_pkg::field_size(sts.data);
    if (rd_acc) begin
      final_r    <= (rp_inc == {1'b0, len_r});
      sect_out_r <= sect_r;
    end
  end

  always_comb begin
    sts.nm        = (ptr_r >= PW'(len_r));
    sts.data      = trk_q_r;
    sts.base_done = (base_r >= PW'(len_r));
    sts.cnt_one   = (cnt_r == PW'(1));
    sts.j         = j_r;
    sts.mode      = mode_r;
  end

  assign out_valid               = out_valid_r;
  assign out_data.track_byte     = trk_q_r;
  assign out_data.clock_byte     = clk_q_r;
  assign out_data.final_position = final_r;
  assign out_data.sector_count   = sect_out_r;

endmodule

@@ hw/rtl/ftcp_checker.sv @@
// Port-level checks of the floppy track CRC patcher, bound to the top level.
// Depends on ftcp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ftcp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input ftcp_pkg::in_req_t  in_req,
  input logic               out_valid
);

  logic rd_req, ld_req;

  assign rd_req = start && !busy && in_req.operation;
  assign ld_req = start && !busy && !in_req.operation;

  `FTCP_ASSERT_IMP(a_result_needs_read, out_valid, $past(rd_req), "result without read request")
  `FTCP_ASSERT_NXT(a_load_no_result, ld_req, !out_valid, "result after load request")
  `FTCP_ASSERT_IMP(a_pass_needs_last, $rose(busy), $past(ld_req && in_req.last_byte), "pass started without last byte")
  `FTCP_ASSERT_IMP(a_result_while_idle, out_valid, !busy, "result during patch pass")

endmodule

bind floppy_track_crc_patcher_top ftcp_checker u_ftcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid)
);

@@ dv/tb_top.sv @@
// Testbench for floppy_track_crc_patcher_top: loads FM and MFM tracks, reads them back
// and checks every result against an in-bench model of the patch pass or a typed expectation.
// Depends on ftcp_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int NTRK = ftcp_pkg::MAX_TRACK_BYTES;
  localparam int LIMIT = 3000000;
  localparam int NO_HIT = 256;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  ftcp_pkg::in_req_t in_req = '0;
  logic out_valid;
  ftcp_pkg::out_rsp_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  floppy_track_crc_patcher_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // shadow of the block
  logic [7:0] trk_mem [NTRK];
  logic [7:0] clk_mem [NTRK];
  int trk_len, load_ptr, read_ptr, sect_cnt;
  logic [15:0] crc;
  bit fm_mode;

  ftcp_pkg::out_rsp_t readout_q[$];
  byte unsigned track_q[$];
  int errors = 0;
  int cycles = 0;
  int items = 0;
  bit no_idle = 0;

  function automatic int rd(longint p);
    return (p >= trk_len) ? NO_HIT : int'(trk_mem[p]);
  endfunction

  function automatic void wr_d(longint p, int v);
    if (p < trk_len) trk_mem[p] = v[7:0];
  endfunction

  function automatic void wr_c(longint p, int v);
    if (p < trk_len) clk_mem[p] = v[7:0];
  endfunction

  function automatic void crc_over(longint s, longint n);
    int b;
    crc = 16'hFFFF;
    for (longint k = 0; k < n; k++) begin
      b = rd(s + k);
      crc = crc ^ {b[7:0], 8'h00};
      for (int i = 0; i < 8; i++) crc = crc[15] ? ((crc << 1) ^ 16'h1021) : (crc << 1);
    end
  endfunction

  function automatic void crc_put(longint p);
    wr_d(p, crc[15:8]);
    wr_d(p + 1, crc[7:0]);
  endfunction

  function automatic longint data_len(int code);
    if (code > 16) code = 16;
    return longint'(128) << code;
  endfunction

  function automatic bit sync_at(longint p, int m);
    return rd(p) == 8'hA1 && rd(p + 1) == 8'hA1 && rd(p + 2) == 8'hA1 && rd(p + 3) == m;
  endfunction

  function automatic void sync_clocks(longint p);
    wr_c(p, 8'h0A); wr_c(p + 1, 8'h0A); wr_c(p + 2, 8'h0A); wr_c(p + 3, 8'hFF);
  endfunction

  function automatic int patch_fm();
    int n = 0, m;
    longint i = 0, sz;
    while (i < trk_len) begin
      if (rd(i) == 8'hFE) begin
        wr_c(i, 8'hC7);
        if (rd(i + 5) == 8'hF7 && rd(i + 6) == 8'hF7) begin
          sz = data_len(rd(i + 4));
          crc_over(i, 5);
          crc_put(i + 5);
          for (longint j = 12; j < 32; j++) begin
            m = rd(i + j);
            if (m == 8'hFB || m == 8'hF8) begin
              wr_c(i + j, 8'hC7);
              if (rd(i + j + sz + 1) == 8'hF7 && rd(i + j + sz + 2) == 8'hF7) begin
                crc_over(i + j, sz + 1);
                crc_put(i + j + sz + 1);
                i = i + j + sz + 3;
                if (n < 255) n++;
                break;
              end
            end
          end
        end
      end
      i++;
    end
    return n;
  endfunction

  function automatic int patch_mfm();
    int n = 0;
    longint i = 0, sz, s;
    while (i < trk_len) begin
      if (sync_at(i, 8'hFE)) begin
        s = i;
        sync_clocks(i);
        i += 3;
        if (rd(i + 5) == 8'hF7 && rd(i + 6) == 8'hF7) begin
          sz = data_len(rd(i + 4));
          crc_over(s, 8);
          crc_put(i + 5);
          for (longint j = 0; j < 64; j++) begin
            if (sync_at(i + j, 8'hFB)) begin
              sync_clocks(i + j);
              i = i + j + 4;
              if (rd(i + sz) == 8'hF7 && rd(i + sz + 1) == 8'hF7) begin
                crc_over(i - 4, sz + 4);
                crc_put(i + sz);
                wr_c(i + sz, 8'hFF);
                wr_c(i + sz + 1, 8'hFF);
                i = i + sz + 2;
                if (n < 255) n++;
                break;
              end
            end
          end
        end
      end
      i++;
    end
    return n;
  endfunction

  function automatic bit predict(ftcp_pkg::in_req_t r, output ftcp_pkg::out_rsp_t o);
    o = '0;
    if (!r.operation) begin
      if (load_ptr < NTRK) begin
        trk_mem[load_ptr] = r.data_byte;
        clk_mem[load_ptr] = 8'hFF;
        load_ptr++;
      end
      if (r.last_byte) begin
        trk_len = load_ptr;
        load_ptr = 0;
        read_ptr = 0;
        sect_cnt = fm_mode ? patch_fm() : patch_mfm();
      end
      return 0;
    end
    if (trk_len == 0) return 0;
    if (read_ptr >= trk_len) read_ptr = 0;
    o.track_byte = trk_mem[read_ptr];
    o.clock_byte = clk_mem[read_ptr];
    o.final_position = (read_ptr + 1 == trk_len);
    o.sector_count = sect_cnt[7:0];
    read_ptr++;
    if (read_ptr >= trk_len) read_ptr = 0;
    return 1;
  endfunction

  // drive one request; returns once it has been taken
  task automatic issue(ftcp_pkg::in_req_t r, bit use_typed = 0,
                       ftcp_pkg::out_rsp_t typed = '0);
    bit taken;
    ftcp_pkg::out_rsp_t o;
    while (!no_idle && $urandom_range(99) < 26) begin
      start <= 0;
      in_req <= ftcp_pkg::in_req_t'(10'($urandom));
      @(posedge clk);
    end
    start <= 1;
    in_req <= r;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    items++;
    if (predict(r, o)) readout_q.push_back(use_typed ? typed : o);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (readout_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(bit m);
    drain();
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= 3'(ftcp_pkg::REG_ENCODING_MODE) << 2; pwdata <= {31'($urandom), m};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    fm_mode = m;
    @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (readout_q.size() == 0) begin
        $display("%0t: result with none expected: %h", $realtime, out_data);
        errors++;
      end else begin
        ftcp_pkg::out_rsp_t e;
        e = readout_q.pop_front();
        if (e.track_byte !== out_data.track_byte || e.clock_byte !== out_data.clock_byte ||
            e.final_position !== out_data.final_position ||
            e.sector_count !== out_data.sector_count) begin
          $display("%0t: mismatch expected %h/%h/%b/%0d actual %h/%h/%b/%0d", $realtime,
                   e.track_byte, e.clock_byte, e.final_position, e.sector_count,
                   out_data.track_byte, out_data.clock_byte, out_data.final_position,
                   out_data.sector_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void push_fill(int n);
    for (int k = 0; k < n; k++) track_q.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void push_f7s();
    if ($urandom_range(9) == 0) begin
      track_q.push_back(8'hF7);
      track_q.push_back(8'($urandom_range(255)));
    end else begin
      track_q.push_back(8'hF7);
      track_q.push_back(8'hF7);
    end
  endfunction

  // one track of one or two sectors with random content and some breakage, or filler only
  function automatic void make_track();
    int ns, code, r;
    track_q.delete();
    if ($urandom_range(4) == 0) begin
      push_fill($urandom_range(1, 40));
      return;
    end
    push_fill($urandom_range(0, 8));
    ns = $urandom_range(1, 2);
    for (int s = 0; s < ns; s++) begin
      r = $urandom_range(99);
      code = r < 85 ? 0 : (r < 95 ? 1 : $urandom_range(2, 255));
      if (!fm_mode) repeat (3) track_q.push_back(8'hA1);
      track_q.push_back(8'hFE);
      push_fill(3);
      track_q.push_back(8'(code));
      push_f7s();
      if (fm_mode) begin
        push_fill($urandom_range(5, 26));
        track_q.push_back($urandom_range(1) ? 8'hFB : 8'hF8);
      end else begin
        push_fill($urandom_range(0, 58));
        repeat (3) track_q.push_back(8'hA1);
        track_q.push_back(8'hFB);
      end
      push_fill(code <= 1 ? int'(data_len(code)) : $urandom_range(0, 20));
      push_f7s();
      push_fill($urandom_range(0, 10));
    end
  endfunction

  typedef struct {
    bit op;
    byte unsigned d;
    bit last;
    bit chk;
    ftcp_pkg::out_rsp_t e;
  } row_t;

  row_t rows[$];

  initial begin
    ftcp_pkg::in_req_t r;
    int nrd;
    for (int k = 0; k < NTRK; k++) begin
      trk_mem[k] = 8'h00;
      clk_mem[k] = 8'hFF;
    end
    trk_len = 0; load_ptr = 0; read_ptr = 0; sect_cnt = 0; crc = 16'hFFFF; fm_mode = 0;

    // read of empty track, one-byte track with wrap, MFM ID field with oversize code,
    // then a read while a new track is being loaded
    rows.push_back('{1, 8'h00, 0, 0, '0});
    rows.push_back('{0, 8'hFF, 1, 0, '0});
    rows.push_back('{1, 8'hAA, 1, 1, '{8'hFF, 8'hFF, 1'b1, 8'd0}});
    rows.push_back('{1, 8'h55, 0, 1, '{8'hFF, 8'hFF, 1'b1, 8'd0}});
    begin
      byte unsigned idf[10] = '{8'hA1, 8'hA1, 8'hA1, 8'hFE, 8'h00, 8'h00, 8'h01, 8'hFF,
                                8'hF7, 8'hF7};
      for (int k = 0; k < 10; k++) rows.push_back('{0, idf[k], k == 9, 0, '0});
    end
    rows.push_back('{1, 8'h00, 0, 1, '{8'hA1, 8'h0A, 1'b0, 8'd0}});
    repeat (3) rows.push_back('{1, 8'h00, 0, 0, '0});
    rows.push_back('{0, 8'h00, 0, 0, '0});
    rows.push_back('{1, 8'hFF, 0, 0, '0});
    rows.push_back('{0, 8'h7F, 1, 0, '0});
    rows.push_back('{1, 8'h00, 0, 1, '{8'h00, 8'hFF, 1'b0, 8'd0}});
    rows.push_back('{1, 8'h00, 0, 1, '{8'h7F, 8'hFF, 1'b1, 8'd0}});

    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (rows[k]) begin
      r.operation = rows[k].op;
      r.data_byte = rows[k].d;
      r.last_byte = rows[k].last;
      issue(r, rows[k].chk, rows[k].e);
    end

    set_mode(1);
    while (items < 1750) begin
      if ($urandom_range(3) == 0) set_mode($urandom_range(1));
      no_idle = ($urandom_range(5) == 0);
      make_track();
      foreach (track_q[k]) begin
        r.operation = 0;
        r.data_byte = track_q[k];
        r.last_byte = (k == track_q.size() - 1);
        issue(r);
        if ($urandom_range(199) == 0) begin
          r = ftcp_pkg::in_req_t'(10'($urandom));
          r.operation = 1;
          issue(r);
        end
      end
      if ($urandom_range(5) == 0) drain();
      nrd = $urandom_range(3) == 0 ? $urandom_range(0, 10) : track_q.size() + $urandom_range(3);
      for (int k = 0; k < nrd; k++) begin
        r = ftcp_pkg::in_req_t'(10'($urandom));
        r.operation = 1;
        issue(r);
      end
    end
    no_idle = 0;

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && readout_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
